@@ rtl/core/roe_ef_pkg.sv @@
`timescale 1ns / 1ps

package roe_ef_pkg;

  localparam int unsigned NumLanes  = 2;
  localparam int unsigned LanePlus  = 0;
  localparam int unsigned LaneMinus = 1;

endpackage

@@ rtl/core/roe_eigenvalue_entropy_fix.sv @@
`timescale 1ns / 1ps

// Roe eigenvalues with entropy fix. Each request carries left, right and
// averaged normal velocity and sound speed of one face; the result gives |u|
// and the u+c and u-c eigenvalues, all saturated unsigned. With
// entropy_fix_mode set, an acoustic eigenvalue smaller in magnitude than
// eps = 4*max(0, jump) becomes floor((lambda^2 + eps^2) / (2*eps)). The block
// takes one request per clock and delivers one result per clock while the
// output is not stalled. Behind two front stages and three squaring stages,
// a restoring divider resolves one quotient bit per pipeline stage ahead of
// the output register. Stalls back up stage by stage and empty stages keep
// accepting.

module roe_eigenvalue_entropy_fix #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] vel_left_i,
  input  logic signed [DATA_WIDTH-1:0] sound_left_i,
  input  logic signed [DATA_WIDTH-1:0] vel_right_i,
  input  logic signed [DATA_WIDTH-1:0] sound_right_i,
  input  logic signed [DATA_WIDTH-1:0] vel_avg_i,
  input  logic signed [DATA_WIDTH-1:0] sound_avg_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DATA_WIDTH-1:0]        eig_convective_o,
  output logic [DATA_WIDTH-1:0]        eig_plus_o,
  output logic [DATA_WIDTH-1:0]        eig_minus_o
);

  localparam int unsigned W           = DATA_WIDTH;
  localparam int unsigned NumDivSteps = W + 1;

  logic mode_q;

  logic                                         fr_valid, fr_ready, fr_in_ready;
  logic [W-1:0]                                 fr_conv;
  logic [roe_ef_pkg::NumLanes-1:0][3*W+2:0]     fr_lane;

  logic                                         dv_valid [NumDivSteps+1];
  logic                                         dv_ready [NumDivSteps+1];
  logic [W-1:0]                                 dv_conv  [NumDivSteps+1];
  logic [roe_ef_pkg::NumLanes-1:0][4*W+5:0]     dv_lane  [NumDivSteps+1];

  logic                                         out_valid_q, out_valid_d, out_rdy, out_en;
  logic [W-1:0]                                 conv_q;
  logic [W-1:0]                                 res_d [roe_ef_pkg::NumLanes];
  logic [W-1:0]                                 res_q [roe_ef_pkg::NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  roe_ef_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (fr_in_ready),
    .vel_left_i    (vel_left_i),
    .sound_left_i  (sound_left_i),
    .vel_right_i   (vel_right_i),
    .sound_right_i (sound_right_i),
    .vel_avg_i     (vel_avg_i),
    .sound_avg_i   (sound_avg_i),
    .out_valid_o   (fr_valid),
    .out_ready_i   (fr_ready),
    .conv_o        (fr_conv),
    .lane_o        (fr_lane)
  );

  assign in_stall_o = !fr_in_ready;

  roe_ef_square #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .conv_i      (fr_conv),
    .lane_i      (fr_lane),
    .out_valid_o (dv_valid[0]),
    .out_ready_i (dv_ready[0]),
    .conv_o      (dv_conv[0]),
    .lane_o      (dv_lane[0])
  );

  for (genvar gs = 0; gs < NumDivSteps; gs++) begin : g_div
    roe_ef_div_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[gs]),
      .in_ready_o  (dv_ready[gs]),
      .conv_i      (dv_conv[gs]),
      .lane_i      (dv_lane[gs]),
      .out_valid_o (dv_valid[gs+1]),
      .out_ready_i (dv_ready[gs+1]),
      .conv_o      (dv_conv[gs+1]),
      .lane_o      (dv_lane[gs+1])
    );
  end

  // output register with quotient saturation
  assign out_rdy                 = !out_valid_q || !out_stall_i;
  assign dv_ready[NumDivSteps]   = out_rdy;
  assign out_en                  = out_rdy && dv_valid[NumDivSteps];
  assign out_valid_d             = out_rdy ? dv_valid[NumDivSteps] : out_valid_q;

  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      if (dv_lane[NumDivSteps][i][4*W+5]) begin
        res_d[i] = dv_lane[NumDivSteps][i][W] ? '1 : dv_lane[NumDivSteps][i][W-1:0];
      end else begin
        res_d[i] = dv_lane[NumDivSteps][i][4*W+4:3*W+5];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      res_q  <= res_d;
      conv_q <= dv_conv[NumDivSteps];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign eig_convective_o = conv_q;
  assign eig_plus_o       = res_q[roe_ef_pkg::LanePlus];
  assign eig_minus_o      = res_q[roe_ef_pkg::LaneMinus];

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side can move");

  a_plus_eps_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_lane[roe_ef_pkg::LanePlus][3*W+2])
      |-> (fr_lane[roe_ef_pkg::LanePlus][W:0] != '0))
    else $error("u+c division requested with zero epsilon");

  a_minus_eps_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_lane[roe_ef_pkg::LaneMinus][3*W+2])
      |-> (fr_lane[roe_ef_pkg::LaneMinus][W:0] != '0))
    else $error("u-c division requested with zero epsilon");

  a_plus_quot_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid[0] && dv_lane[0][roe_ef_pkg::LanePlus][4*W+5])
      |-> (dv_lane[0][roe_ef_pkg::LanePlus][2*W+2:W+1]
           < dv_lane[0][roe_ef_pkg::LanePlus][3*W+4:2*W+3]))
    else $error("u+c quotient exceeds divider width");

  a_minus_quot_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid[0] && dv_lane[0][roe_ef_pkg::LaneMinus][4*W+5])
      |-> (dv_lane[0][roe_ef_pkg::LaneMinus][2*W+2:W+1]
           < dv_lane[0][roe_ef_pkg::LaneMinus][3*W+4:2*W+3]))
    else $error("u-c quotient exceeds divider width");

endmodule

@@ rtl/core/roe_ef_front.sv @@
`timescale 1ns / 1ps

module roe_ef_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  mode_i,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]                          vel_left_i,
  input  logic signed [DATA_WIDTH-1:0]                          sound_left_i,
  input  logic signed [DATA_WIDTH-1:0]                          vel_right_i,
  input  logic signed [DATA_WIDTH-1:0]                          sound_right_i,
  input  logic signed [DATA_WIDTH-1:0]                          vel_avg_i,
  input  logic signed [DATA_WIDTH-1:0]                          sound_avg_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [DATA_WIDTH-1:0]                                 conv_o,
  output logic [roe_ef_pkg::NumLanes-1:0][3*DATA_WIDTH+2:0]     lane_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned W1 = W + 1;
  localparam int unsigned W2 = W + 2;
  localparam int unsigned SideLeft  = 0;
  localparam int unsigned SideRight = 1;
  localparam int unsigned SideAvg   = 2;

  // stage a: edge eigenvalues
  logic               va_q, va_d;
  logic               rdy_a, en_a;
  logic               mode_a_q;
  logic signed [W:0]  lam_d [roe_ef_pkg::NumLanes][3];
  logic signed [W:0]  lam_q [roe_ef_pkg::NumLanes][3];
  logic [W-1:0]       ua_u;
  logic [W-1:0]       conv_a_d, conv_a_q;

  // stage b: epsilon, magnitude, fix decision
  logic               vb_q, vb_d;
  logic               rdy_b, en_b;
  logic [W-1:0]       conv_b_q;
  logic [roe_ef_pkg::NumLanes-1:0][3*W+2:0] lane_b_d, lane_b_q;

  logic signed [W+1:0] dif_lo  [roe_ef_pkg::NumLanes];
  logic signed [W+1:0] dif_hi  [roe_ef_pkg::NumLanes];
  logic signed [W+1:0] peak    [roe_ef_pkg::NumLanes];
  logic [W:0]          lam_u   [roe_ef_pkg::NumLanes];
  logic [W:0]          mag_l   [roe_ef_pkg::NumLanes];
  logic [W+2:0]        eps     [roe_ef_pkg::NumLanes];
  logic                use_fix [roe_ef_pkg::NumLanes];
  logic                eps_big [roe_ef_pkg::NumLanes];
  logic [W-1:0]        dflt    [roe_ef_pkg::NumLanes];

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;
  assign en_a       = rdy_a && in_valid_i;
  assign en_b       = rdy_b && va_q;
  assign va_d       = rdy_a ? in_valid_i : va_q;
  assign vb_d       = rdy_b ? va_q : vb_q;

  always_comb begin
    lam_d[roe_ef_pkg::LanePlus][SideLeft]   = W1'(vel_left_i) + W1'(sound_left_i);
    lam_d[roe_ef_pkg::LanePlus][SideRight]  = W1'(vel_right_i) + W1'(sound_right_i);
    lam_d[roe_ef_pkg::LanePlus][SideAvg]    = W1'(vel_avg_i) + W1'(sound_avg_i);
    lam_d[roe_ef_pkg::LaneMinus][SideLeft]  = W1'(vel_left_i) - W1'(sound_left_i);
    lam_d[roe_ef_pkg::LaneMinus][SideRight] = W1'(vel_right_i) - W1'(sound_right_i);
    lam_d[roe_ef_pkg::LaneMinus][SideAvg]   = W1'(vel_avg_i) - W1'(sound_avg_i);
    ua_u     = vel_avg_i;
    conv_a_d = ua_u[W-1] ? (~ua_u + 1'b1) : ua_u;
  end

  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      dif_lo[i] = W2'(lam_q[i][SideAvg]) - W2'(lam_q[i][SideLeft]);
      dif_hi[i] = W2'(lam_q[i][SideRight]) - W2'(lam_q[i][SideAvg]);
      peak[i]   = '0;
      if (dif_lo[i] > peak[i]) begin
        peak[i] = dif_lo[i];
      end
      if (dif_hi[i] > peak[i]) begin
        peak[i] = dif_hi[i];
      end
      eps[i]     = {peak[i][W:0], 2'b00};
      lam_u[i]   = lam_q[i][SideAvg];
      mag_l[i]   = lam_u[i][W] ? (~lam_u[i] + 1'b1) : lam_u[i];
      use_fix[i] = mode_a_q && ({2'b00, mag_l[i]} < eps[i]);
      eps_big[i] = |eps[i][W+2:W+1];
      dflt[i]    = ((use_fix[i] && eps_big[i]) || mag_l[i][W]) ? '1 : mag_l[i][W-1:0];
      lane_b_d[i] = {use_fix[i] && !eps_big[i], dflt[i], mag_l[i], eps[i][W:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      lam_q    <= lam_d;
      conv_a_q <= conv_a_d;
      mode_a_q <= mode_i;
    end
    if (en_b) begin
      lane_b_q <= lane_b_d;
      conv_b_q <= conv_a_q;
    end
  end

  assign out_valid_o = vb_q;
  assign conv_o      = conv_b_q;
  assign lane_o      = lane_b_q;

endmodule

@@ rtl/core/roe_ef_square.sv @@
`timescale 1ns / 1ps

module roe_ef_square #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic [DATA_WIDTH-1:0]                             conv_i,
  input  logic [roe_ef_pkg::NumLanes-1:0][3*DATA_WIDTH+2:0] lane_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [DATA_WIDTH-1:0]                             conv_o,
  output logic [roe_ef_pkg::NumLanes-1:0][4*DATA_WIDTH+5:0] lane_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned H   = (W + 2) / 2;
  localparam int unsigned HW  = W + 1 - H;
  localparam int unsigned SqW = 2 * W + 2;
  localparam int unsigned DvW = 2 * W + 3;
  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] v_q, v_d, rdy, en;

  // operand 0 is |lambda|, operand 1 is epsilon
  logic [W:0]        op     [roe_ef_pkg::NumLanes][2];
  logic [HW-1:0]     op_hi  [roe_ef_pkg::NumLanes][2];
  logic [H-1:0]      op_lo  [roe_ef_pkg::NumLanes][2];

  logic [2*HW-1:0]   hh_d   [roe_ef_pkg::NumLanes][2];
  logic [2*HW-1:0]   hh_q   [roe_ef_pkg::NumLanes][2];
  logic [HW+H-1:0]   hl_d   [roe_ef_pkg::NumLanes][2];
  logic [HW+H-1:0]   hl_q   [roe_ef_pkg::NumLanes][2];
  logic [2*H-1:0]    ll_d   [roe_ef_pkg::NumLanes][2];
  logic [2*H-1:0]    ll_q   [roe_ef_pkg::NumLanes][2];
  logic [2*W+1:0]    meta_s1_d [roe_ef_pkg::NumLanes];
  logic [2*W+1:0]    meta_s1_q [roe_ef_pkg::NumLanes];
  logic [W-1:0]      conv_s1_q;

  logic [SqW-1:0]    sq_d   [roe_ef_pkg::NumLanes][2];
  logic [SqW-1:0]    sq_q   [roe_ef_pkg::NumLanes][2];
  logic [2*W+1:0]    meta_s2_q [roe_ef_pkg::NumLanes];
  logic [W-1:0]      conv_s2_q;

  logic [DvW-1:0]    dvd    [roe_ef_pkg::NumLanes];
  logic [roe_ef_pkg::NumLanes-1:0][4*W+5:0] lane_s3_d, lane_s3_q;
  logic [W-1:0]      conv_s3_q;

  always_comb begin
    rdy[2] = !v_q[2] || out_ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
    en[0]  = rdy[0] && in_valid_i;
    en[1]  = rdy[1] && v_q[0];
    en[2]  = rdy[2] && v_q[1];
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    v_d[1] = rdy[1] ? v_q[0] : v_q[1];
    v_d[2] = rdy[2] ? v_q[1] : v_q[2];
  end

  assign in_ready_o = rdy[0];

  // split products
  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      op[i][0]     = lane_i[i][2*W+1:W+1];
      op[i][1]     = lane_i[i][W:0];
      meta_s1_d[i] = {lane_i[i][3*W+2:2*W+2], lane_i[i][W:0]};
      for (int k = 0; k < 2; k++) begin
        op_hi[i][k] = op[i][k][W:H];
        op_lo[i][k] = op[i][k][H-1:0];
        hh_d[i][k]  = op_hi[i][k] * op_hi[i][k];
        hl_d[i][k]  = op_hi[i][k] * op_lo[i][k];
        ll_d[i][k]  = op_lo[i][k] * op_lo[i][k];
      end
    end
  end

  // recombine squares
  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      for (int k = 0; k < 2; k++) begin
        sq_d[i][k] = (SqW'(hh_q[i][k]) << (2 * H)) + (SqW'(hl_q[i][k]) << (H + 1))
                     + SqW'(ll_q[i][k]);
      end
    end
  end

  // dividend and divisor
  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      dvd[i]       = DvW'(sq_q[i][0]) + DvW'(sq_q[i][1]);
      lane_s3_d[i] = {meta_s2_q[i][2*W+1:W+1], meta_s2_q[i][W:0], 1'b0, dvd[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hh_q      <= hh_d;
      hl_q      <= hl_d;
      ll_q      <= ll_d;
      meta_s1_q <= meta_s1_d;
      conv_s1_q <= conv_i;
    end
    if (en[1]) begin
      sq_q      <= sq_d;
      meta_s2_q <= meta_s1_q;
      conv_s2_q <= conv_s1_q;
    end
    if (en[2]) begin
      lane_s3_q <= lane_s3_d;
      conv_s3_q <= conv_s2_q;
    end
  end

  assign out_valid_o = v_q[2];
  assign conv_o      = conv_s3_q;
  assign lane_o      = lane_s3_q;

endmodule

@@ rtl/core/roe_ef_div_step.sv @@
`timescale 1ns / 1ps

module roe_ef_div_step #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic [DATA_WIDTH-1:0]                             conv_i,
  input  logic [roe_ef_pkg::NumLanes-1:0][4*DATA_WIDTH+5:0] lane_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [DATA_WIDTH-1:0]                             conv_o,
  output logic [roe_ef_pkg::NumLanes-1:0][4*DATA_WIDTH+5:0] lane_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic         valid_q, valid_d, en;
  logic [W-1:0] conv_q;
  logic [roe_ef_pkg::NumLanes-1:0][4*W+5:0] lane_d, lane_q;

  logic [W+1:0] rem  [roe_ef_pkg::NumLanes];
  logic [W:0]   dq   [roe_ef_pkg::NumLanes];
  logic [W+1:0] den  [roe_ef_pkg::NumLanes];
  logic [W+2:0] shf  [roe_ef_pkg::NumLanes];
  logic [W+2:0] dif  [roe_ef_pkg::NumLanes];
  logic         ge   [roe_ef_pkg::NumLanes];

  assign in_ready_o = !valid_q || out_ready_i;
  assign en         = in_ready_o && in_valid_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  // one restoring step: partial remainder takes the next dividend bit,
  // the quotient bit shifts in where the dividend bit left
  always_comb begin
    for (int i = 0; i < roe_ef_pkg::NumLanes; i++) begin
      dq[i]     = lane_i[i][W:0];
      rem[i]    = lane_i[i][2*W+2:W+1];
      den[i]    = lane_i[i][3*W+4:2*W+3];
      shf[i]    = {rem[i], dq[i][W]};
      ge[i]     = shf[i] >= {1'b0, den[i]};
      dif[i]    = shf[i] - {1'b0, den[i]};
      lane_d[i] = {lane_i[i][4*W+5:2*W+3], ge[i] ? dif[i][W+1:0] : shf[i][W+1:0],
                   dq[i][W-1:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q <= lane_d;
      conv_q <= conv_i;
    end
  end

  assign out_valid_o = valid_q;
  assign conv_o      = conv_q;
  assign lane_o      = lane_q;

endmodule

@@ test/roe_ef_checker.sv @@
`timescale 1ns / 1ps

module roe_ef_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] vel_left_i,
  input  logic signed [31:0] sound_left_i,
  input  logic signed [31:0] vel_right_i,
  input  logic signed [31:0] sound_right_i,
  input  logic signed [31:0] vel_avg_i,
  input  logic signed [31:0] sound_avg_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        eig_convective_i,
  input  logic [31:0]        eig_plus_i,
  input  logic [31:0]        eig_minus_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [63:0] EIG_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] conv;
    logic [31:0] plus;
    logic [31:0] minus;
  } eig_t;

  eig_t eig_q[$];
  logic fix_mode = 1'b0;
  int   fails = 0;

  assign fail_count_o = fails;

  // entropy-fixed magnitude of one acoustic eigenvalue
  function automatic logic [31:0] acoustic_eig(longint lam_l, longint lam_r, longint lam,
                                               logic fix);
    logic [63:0]  mag;
    logic [63:0]  eps;
    logic [127:0] num;
    logic [127:0] quo;
    longint       jump;
    mag = (lam < 0) ? -lam : lam;
    if (fix) begin
      jump = 0;
      if (lam - lam_l > jump) jump = lam - lam_l;
      if (lam_r - lam > jump) jump = lam_r - lam;
      eps = jump * 4;
      if (mag < eps) begin
        num = {64'd0, mag} * {64'd0, mag} + {64'd0, eps} * {64'd0, eps};
        quo = num / {63'd0, eps, 1'b0};
        return (quo > {64'd0, EIG_MAX}) ? EIG_MAX[31:0] : quo[31:0];
      end
    end
    return (mag > EIG_MAX) ? EIG_MAX[31:0] : mag[31:0];
  endfunction

  function automatic eig_t predict_face(logic fix,
                                        logic signed [31:0] vl, logic signed [31:0] cl,
                                        logic signed [31:0] vr, logic signed [31:0] cr,
                                        logic signed [31:0] va, logic signed [31:0] ca);
    longint      ul, sl, ur, sr, ua, sa;
    logic [63:0] conv_mag;
    eig_t        res;
    ul = vl;
    sl = cl;
    ur = vr;
    sr = cr;
    ua = va;
    sa = ca;
    conv_mag  = (ua < 0) ? -ua : ua;
    res.conv  = conv_mag[31:0];
    res.plus  = acoustic_eig(ul + sl, ur + sr, ua + sa, fix);
    res.minus = acoustic_eig(ul - sl, ur - sr, ua - sa, fix);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    eig_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (eig_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h %h", $time,
                   eig_convective_i, eig_plus_i, eig_minus_i);
          fails++;
        end else begin
          want = eig_q.pop_front();
          check_field("eig_convective", want.conv, eig_convective_i);
          check_field("eig_plus", want.plus, eig_plus_i);
          check_field("eig_minus", want.minus, eig_minus_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        eig_q.push_back(predict_face(fix_mode, vel_left_i, sound_left_i, vel_right_i,
                                     sound_right_i, vel_avg_i, sound_avg_i));
      end
      if (cfg_we_i) begin
        fix_mode <= cfg_wdata_i;
      end
    end
    pending_o <= eig_q.size();
  end

endmodule

@@ test/tb_roe_eigenvalue_entropy_fix.sv @@
`timescale 1ns / 1ps

module tb_roe_eigenvalue_entropy_fix;

  localparam int W            = 32;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 225;
  localparam int TAIL_CYCLES  = 50;
  localparam logic FIX_OFF    = 1'b0;
  localparam logic FIX_ON     = 1'b1;
  localparam logic [W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0] NEG_MAX = 32'h8000_0000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_wdata_i   = 1'b0;
  logic         in_valid_i    = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] vel_left_i    = '0;
  logic [W-1:0] sound_left_i  = '0;
  logic [W-1:0] vel_right_i   = '0;
  logic [W-1:0] sound_right_i = '0;
  logic [W-1:0] vel_avg_i     = '0;
  logic [W-1:0] sound_avg_i   = '0;
  logic         out_valid_o;
  logic         out_stall_i   = 1'b0;
  logic [W-1:0] eig_convective_o;
  logic [W-1:0] eig_plus_o;
  logic [W-1:0] eig_minus_o;

  int   fail_count;
  int   pending;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   quiet_count = 0;
  logic hold_req    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  roe_eigenvalue_entropy_fix #(
    .DATA_WIDTH(W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .vel_left_i      (vel_left_i),
    .sound_left_i    (sound_left_i),
    .vel_right_i     (vel_right_i),
    .sound_right_i   (sound_right_i),
    .vel_avg_i       (vel_avg_i),
    .sound_avg_i     (sound_avg_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .eig_convective_o(eig_convective_o),
    .eig_plus_o      (eig_plus_o),
    .eig_minus_o     (eig_minus_o)
  );

  roe_ef_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .vel_left_i      (vel_left_i),
    .sound_left_i    (sound_left_i),
    .vel_right_i     (vel_right_i),
    .sound_right_i   (sound_right_i),
    .vel_avg_i       (vel_avg_i),
    .sound_avg_i     (sound_avg_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .eig_convective_i(eig_convective_o),
    .eig_plus_i      (eig_plus_o),
    .eig_minus_i     (eig_minus_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // receiver, with one long hold-off in the first random segment
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic logic [W-1:0] scaled(int sh);
    return $signed($urandom) >>> (31 - sh);
  endfunction

  task automatic send_face(logic [W-1:0] vl, logic [W-1:0] cl, logic [W-1:0] vr,
                           logic [W-1:0] cr, logic [W-1:0] va, logic [W-1:0] ca);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vel_left_i    <= vl;
    sound_left_i  <= cl;
    vel_right_i   <= vr;
    sound_right_i <= cr;
    vel_avg_i     <= va;
    sound_avg_i   <= ca;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(logic mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_directed();
    send_face('0, '0, '0, '0, '0, '0);
    send_face(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    // |u+c| reaches 2^32, saturates
    send_face(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    send_face('0, '0, '0, '0, POS_MAX, POS_MAX);
    send_face('0, '0, '0, '0, NEG_MAX, POS_MAX);
    // transonic face, both lanes fixed
    send_face(32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'hFFFF_8000, 32'h0001_0000);
    // uniform flow, zero epsilon
    send_face(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000);
    // negative sound speed
    send_face(32'h0000_4000, 32'hFFFD_0000, 32'h0000_8000, 32'hFFFD_0000,
              32'h0000_4000, 32'hFFFD_0000);
    // huge jump, quotient saturates
    send_face(NEG_MAX, NEG_MAX, '0, '0, '0, '0);
    // magnitude equal to epsilon, then just below
    send_face(32'd3, '0, 32'd4, '0, 32'd4, '0);
    send_face(32'd2, '0, 32'd3, '0, 32'd3, '0);
    send_face(32'h1234_5678, NEG_MAX, POS_MAX, NEG_MAX, 32'hFEDC_BA98, 32'h0000_0001);
  endtask

  task automatic send_random();
    int           sh;
    int           dsh;
    logic [W-1:0] ua;
    logic [W-1:0] ca;
    if ($urandom_range(9) < 2) begin
      send_face($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      sh  = $urandom_range(30, 2);
      dsh = $urandom_range(sh, 0);
      ua  = scaled(sh);
      case ($urandom_range(2))
        0: ca = -ua + scaled(sh - 2);
        1: ca = ua + scaled(sh - 2);
        default: ca = scaled(sh);
      endcase
      send_face(ua + scaled(dsh), ca + scaled(dsh), ua + scaled(dsh), ca + scaled(dsh),
                ua, ca);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_mode(FIX_OFF);
    run_directed();
    set_mode(FIX_ON);
    run_directed();
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      set_mode(seg[0] ? FIX_ON : FIX_OFF);
      if (seg == 0) begin
        hold_req = 1'b1;
      end
      repeat (SEG_ITEMS) send_random();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
